// ===== src/imu_offset_correct_and_calibrate_assert.svh =====
// Assertion macros for the IMU offset correction block.
// Included by modules that check their own logic; needs i_clk and i_rst_n in scope.
`ifndef IMU_OFFSET_CORRECT_AND_CALIBRATE_ASSERT_SVH
`define IMU_OFFSET_CORRECT_AND_CALIBRATE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IMUOC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define IMUOC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/imuoc_pkg.sv =====
// Package for the IMU offset correction block: widths, constants, types, helpers.
// No dependencies.
`default_nettype none

package imuoc_pkg;

    // Field and state widths
    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = 24;
    localparam int CNT_W       = 8;
    localparam int DB_W        = 8;
    localparam int AXES        = 3;

    // Calibration length and deadband reset value
    localparam int CAL_SAMPLES = 200;
    localparam logic [DB_W-1:0] DB_RESET = DB_W'(5);

    // Truncating divide by CAL_SAMPLES as a reciprocal multiply.
    // A full sum magnitude stays below 2^MAG_W and the reciprocal error below
    // 2^CNT_W, so a shift of MAG_W + CNT_W gives the exact floor quotient.
    localparam int     MAG_W    = SUM_W - 1;
    localparam int     RECIP_SH = MAG_W + CNT_W;
    localparam longint RECIP    = ((longint'(1) << RECIP_SH) + longint'(CAL_SAMPLES) - 1)
                                  / longint'(CAL_SAMPLES);
    localparam int     RECIP_W  = $clog2(RECIP + 1);
    localparam int     PROD_W   = MAG_W + RECIP_W;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]    t_sum;

    typedef struct packed {
        t_sample acc_x;
        t_sample acc_y;
        t_sample acc_z;
        t_sample gyro_x;
        t_sample gyro_y;
        t_sample gyro_z;
        logic    gyro_busy;
        logic    acc_busy;
    } t_result;

    localparam t_sample SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam t_sample SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // a - b, saturated to the sample range
    function automatic t_sample sat_sub(input t_sample a, input t_sample b);
        logic signed [SAMPLE_W:0] d;
        d = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
        if (d[SAMPLE_W] != d[SAMPLE_W-1]) begin
            return d[SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX;
        end
        return d[SAMPLE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/imu_offset_correct_and_calibrate.sv =====
// The result of a taken input transaction is registered in the result or skid register.
// Throughput: one transaction per cycle; the input stalls while the skid register holds a
// result, and while the divider is busy after the item that ends a calibration, as the sums
// are divided by CAL_SAMPLES (reciprocal multiply), so the next item sees the new offsets.
// Reset (synchronous, active low): offsets, sums, counters cleared, deadband set to 5.
// Depends on imuoc_pkg and imu_offset_correct_and_calibrate_assert.svh.
`default_nettype none

module imu_offset_correct_and_calibrate (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // sample input channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic signed [imuoc_pkg::SAMPLE_W-1:0] i_acc_x_raw,
    input  wire logic signed [imuoc_pkg::SAMPLE_W-1:0] i_acc_y_raw,
    input  wire logic signed [imuoc_pkg::SAMPLE_W-1:0] i_acc_z_raw,
    input  wire logic signed [imuoc_pkg::SAMPLE_W-1:0] i_gyro_x_raw,
    input  wire logic signed [imuoc_pkg::SAMPLE_W-1:0] i_gyro_y_raw,
    input  wire logic signed [imuoc_pkg::SAMPLE_W-1:0] i_gyro_z_raw,
    input  wire logic                              i_start_gyro_cal,
    input  wire logic                              i_start_acc_cal,
    // result channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic signed [imuoc_pkg::SAMPLE_W-1:0]  o_acc_x_out,
    output logic signed [imuoc_pkg::SAMPLE_W-1:0]  o_acc_y_out,
    output logic signed [imuoc_pkg::SAMPLE_W-1:0]  o_acc_z_out,
    output logic signed [imuoc_pkg::SAMPLE_W-1:0]  o_gyro_x_out,
    output logic signed [imuoc_pkg::SAMPLE_W-1:0]  o_gyro_y_out,
    output logic signed [imuoc_pkg::SAMPLE_W-1:0]  o_gyro_z_out,
    output logic                                   o_gyro_cal_busy,
    output logic                                   o_acc_cal_busy,
    // deadband register write channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [imuoc_pkg::DB_W-1:0]        i_cfg_data
);
    import imuoc_pkg::*;

    `include "imu_offset_correct_and_calibrate_assert.svh"

    localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(CAL_SAMPLES);
    localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);
    localparam logic [PROD_W-1:0] RECIP_VAL = PROD_W'(RECIP);

    // Calibration state
    t_sample             r_gyro_off [AXES];
    t_sample             r_acc_off  [AXES];
    t_sum                r_gyro_sum [AXES];
    t_sum                r_acc_sum  [2];
    logic [CNT_W-1:0]    r_gyro_cnt, r_acc_cnt;
    logic                r_gyro_act, r_acc_act;
    logic [DB_W-1:0]     r_deadband;

    t_sample             n_gyro_off [AXES];
    t_sample             n_acc_off  [AXES];
    t_sum                n_gyro_sum [AXES];
    t_sum                n_acc_sum  [2];
    logic [CNT_W-1:0]    n_gyro_cnt, n_acc_cnt;
    logic                n_gyro_act, n_acc_act;

    // Divider lanes: sum magnitude and sign, captured when a divide starts
    logic [MAG_W-1:0]     r_div_mag [AXES];
    logic                 r_div_neg [AXES];
    logic                 r_div_busy;
    logic                 r_div_acc;
    logic                 div_start;
    logic                 div_for_acc;
    t_sum                 div_src  [AXES];
    logic [PROD_W-1:0]    div_prod [AXES];
    t_sample              div_q    [AXES];
    logic                 div_done;

    // Output buffer: result register plus skid register
    t_result             r_out, r_skid;
    logic                r_out_valid, r_skid_valid;
    t_result             res;

    logic                in_accept, out_pop;
    t_sample             acc_c  [AXES];
    t_sample             gyro_c [AXES];
    t_sample             gyro_z_db;
    logic signed [SAMPLE_W:0] gz_ext, db_ext;
    logic                g_act, a_act, acc_runs;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_pop     = r_out_valid && !i_out_stall;
    assign o_in_stall  = r_skid_valid || r_div_busy;
    assign o_cfg_ready = 1'b1;
    assign div_done    = r_div_busy;

    // Offset subtraction with saturation
    assign acc_c[0]  = sat_sub(i_acc_x_raw,  r_acc_off[0]);
    assign acc_c[1]  = sat_sub(i_acc_y_raw,  r_acc_off[1]);
    assign acc_c[2]  = sat_sub(i_acc_z_raw,  r_acc_off[2]);
    assign gyro_c[0] = sat_sub(i_gyro_x_raw, r_gyro_off[0]);
    assign gyro_c[1] = sat_sub(i_gyro_y_raw, r_gyro_off[1]);
    assign gyro_c[2] = sat_sub(i_gyro_z_raw, r_gyro_off[2]);

    // Gyro Z deadband
    assign gz_ext    = {gyro_c[2][SAMPLE_W-1], gyro_c[2]};
    assign db_ext    = {{(SAMPLE_W+1-DB_W){1'b0}}, r_deadband};
    assign gyro_z_db = ((gz_ext <= db_ext) && (gz_ext >= -db_ext)) ? '0 : gyro_c[2];

    // Calibration step for the accepted item
    always_comb begin
        n_gyro_off  = r_gyro_off;
        n_acc_off   = r_acc_off;
        n_gyro_sum  = r_gyro_sum;
        n_acc_sum   = r_acc_sum;
        n_gyro_cnt  = r_gyro_cnt;
        n_acc_cnt   = r_acc_cnt;
        n_gyro_act  = r_gyro_act;
        n_acc_act   = r_acc_act;
        div_start   = 1'b0;
        div_for_acc = 1'b0;
        g_act       = r_gyro_act || i_start_gyro_cal;
        a_act       = r_acc_act || i_start_acc_cal;
        acc_runs    = 1'b1;

        if (in_accept) begin
            n_gyro_act = g_act;
            n_acc_act  = a_act;
            if (g_act) begin
                if (r_gyro_cnt == '0) begin
                    for (int i = 0; i < AXES; i++) begin
                        n_gyro_sum[i] = '0;
                        n_gyro_off[i] = '0;
                    end
                    n_gyro_cnt = CNT_ONE;
                    acc_runs   = 1'b0;
                end else begin
                    n_gyro_sum[0] = r_gyro_sum[0] + t_sum'(gyro_c[0]);
                    n_gyro_sum[1] = r_gyro_sum[1] + t_sum'(gyro_c[1]);
                    n_gyro_sum[2] = r_gyro_sum[2] + t_sum'(gyro_z_db);
                    if (r_gyro_cnt == CNT_LAST) begin
                        div_start  = 1'b1;
                        n_gyro_cnt = '0;
                        n_gyro_act = 1'b0;
                        acc_runs   = 1'b0;
                    end else begin
                        n_gyro_cnt = r_gyro_cnt + CNT_ONE;
                    end
                end
            end
            if (acc_runs && a_act) begin
                if (r_acc_cnt == '0) begin
                    n_acc_sum[0] = '0;
                    n_acc_sum[1] = '0;
                    for (int i = 0; i < AXES; i++) begin
                        n_acc_off[i] = '0;
                    end
                    n_acc_cnt = CNT_ONE;
                end else begin
                    n_acc_sum[0] = r_acc_sum[0] + t_sum'(acc_c[0]);
                    n_acc_sum[1] = r_acc_sum[1] + t_sum'(acc_c[1]);
                    if (r_acc_cnt == CNT_LAST) begin
                        div_start   = 1'b1;
                        div_for_acc = 1'b1;
                        n_acc_off[2] = '0;
                        n_acc_cnt   = '0;
                        n_acc_act   = 1'b0;
                    end else begin
                        n_acc_cnt = r_acc_cnt + CNT_ONE;
                    end
                end
            end
        end

        // Load averaged offsets when the divider finishes
        if (div_done) begin
            if (r_div_acc) begin
                n_acc_off[0] = div_q[0];
                n_acc_off[1] = div_q[1];
                n_acc_off[2] = '0;
            end else begin
                for (int i = 0; i < AXES; i++) begin
                    n_gyro_off[i] = div_q[i];
                end
            end
        end
    end

    // Divider source: final sums of the finishing calibration
    assign div_src[0] = div_for_acc ? n_acc_sum[0] : n_gyro_sum[0];
    assign div_src[1] = div_for_acc ? n_acc_sum[1] : n_gyro_sum[1];
    assign div_src[2] = div_for_acc ? '0           : n_gyro_sum[2];

    // Magnitude times reciprocal, then the sign is put back (truncation toward zero)
    always_comb begin
        for (int l = 0; l < AXES; l++) begin
            div_prod[l] = PROD_W'(r_div_mag[l]) * RECIP_VAL;
            div_q[l]    = r_div_neg[l] ? SAMPLE_W'(-div_prod[l][RECIP_SH +: SAMPLE_W])
                                       : div_prod[l][RECIP_SH +: SAMPLE_W];
        end
    end

    // Result of the accepted item
    always_comb begin
        res.acc_x     = acc_c[0];
        res.acc_y     = acc_c[1];
        res.acc_z     = acc_c[2];
        res.gyro_x    = gyro_c[0];
        res.gyro_y    = gyro_c[1];
        res.gyro_z    = gyro_z_db;
        res.gyro_busy = n_gyro_act;
        res.acc_busy  = n_acc_act;
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXES; i++) begin
                r_gyro_off[i] <= '0;
                r_acc_off[i]  <= '0;
                r_gyro_sum[i] <= '0;
            end
            r_acc_sum[0] <= '0;
            r_acc_sum[1] <= '0;
            r_gyro_cnt   <= '0;
            r_acc_cnt    <= '0;
            r_gyro_act   <= 1'b0;
            r_acc_act    <= 1'b0;
            r_deadband   <= DB_RESET;
            r_div_busy   <= 1'b0;
            r_div_acc    <= 1'b0;
        end else begin
            r_gyro_off <= n_gyro_off;
            r_acc_off  <= n_acc_off;
            r_gyro_sum <= n_gyro_sum;
            r_acc_sum  <= n_acc_sum;
            r_gyro_cnt <= n_gyro_cnt;
            r_acc_cnt  <= n_acc_cnt;
            r_gyro_act <= n_gyro_act;
            r_acc_act  <= n_acc_act;
            if (i_cfg_valid && o_cfg_ready) begin
                r_deadband <= i_cfg_data;
            end
            if (div_start) begin
                r_div_busy <= 1'b1;
                r_div_acc  <= div_for_acc;
            end else if (r_div_busy) begin
                r_div_busy <= 1'b0;
            end
        end
    end

    // Divider lane operands
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < AXES; l++) begin
            if (div_start) begin
                r_div_neg[l] <= div_src[l][SUM_W-1];
                r_div_mag[l] <= div_src[l][SUM_W-1] ? MAG_W'(-div_src[l])
                                                    : MAG_W'(div_src[l]);
            end
        end
    end

    // Output buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (out_pop) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (in_accept) begin
                r_out_valid <= 1'b1;
                if (r_out_valid && !out_pop) begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output buffer payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_pop) begin
                r_out <= r_skid;
            end
        end else if (in_accept) begin
            if (!r_out_valid || out_pop) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_acc_x_out     = r_out.acc_x;
    assign o_acc_y_out     = r_out.acc_y;
    assign o_acc_z_out     = r_out.acc_z;
    assign o_gyro_x_out    = r_out.gyro_x;
    assign o_gyro_y_out    = r_out.gyro_y;
    assign o_gyro_z_out    = r_out.gyro_z;
    assign o_gyro_cal_busy = r_out.gyro_busy;
    assign o_acc_cal_busy  = r_out.acc_busy;

    // Checks
    `IMUOC_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid, "skid full, output empty")
    `IMUOC_ASSERT_NOW(a_gyro_cnt_active, r_gyro_cnt != '0, r_gyro_act, "gyro count, no cal")
    `IMUOC_ASSERT_NOW(a_acc_cnt_active, r_acc_cnt != '0, r_acc_act, "acc count, no cal")
    `IMUOC_ASSERT_NEXT(a_div_ends, div_done, !r_div_busy, "divider did not finish")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for imu_offset_correct_and_calibrate: a directed table, then random sample phases
// checked against a behavioral model of offset correction and bias calibration.
// Depends on imuoc_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb;
    import imuoc_pkg::*;

    localparam int RANDOM_ITEMS    = 1950;
    localparam int CALM_ITEMS      = 150;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int SETTLE_CYCLES   = 12;
    localparam int TAIL_CYCLES     = 20;
    localparam int DRAIN_LIMIT     = 2000;
    localparam int CYCLE_LIMIT     = 400000;

    typedef struct packed {
        t_sample acc_x;
        t_sample acc_y;
        t_sample acc_z;
        t_sample gyro_x;
        t_sample gyro_y;
        t_sample gyro_z;
        logic    start_gyro;
        logic    start_acc;
    } t_imu_frame;

    // One directed row: stimulus, whether a typed result is given, and that result
    typedef struct packed {
        t_imu_frame frame;
        logic       typed;
        t_result    result;
    } t_dir_row;

    typedef enum {VAL_UNIFORM, VAL_EXTREME, VAL_NEAR} t_val_mode;
    typedef enum {PH_NOISE, PH_GYRO_CAL, PH_ACC_CAL, PH_BOTH_CAL} t_phase_kind;

    // Clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    // Block inputs, known from time zero
    logic       in_valid = 1'b0;
    t_imu_frame in_frame = '0;
    logic       out_stall = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [DB_W-1:0] cfg_data = '0;

    logic    in_stall;
    logic    out_valid;
    t_sample acc_x_out, acc_y_out, acc_z_out;
    t_sample gyro_x_out, gyro_y_out, gyro_z_out;
    logic    gyro_busy_out, acc_busy_out;
    logic    cfg_ready;

    imu_offset_correct_and_calibrate DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_acc_x_raw      (in_frame.acc_x),
        .i_acc_y_raw      (in_frame.acc_y),
        .i_acc_z_raw      (in_frame.acc_z),
        .i_gyro_x_raw     (in_frame.gyro_x),
        .i_gyro_y_raw     (in_frame.gyro_y),
        .i_gyro_z_raw     (in_frame.gyro_z),
        .i_start_gyro_cal (in_frame.start_gyro),
        .i_start_acc_cal  (in_frame.start_acc),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_acc_x_out      (acc_x_out),
        .o_acc_y_out      (acc_y_out),
        .o_acc_z_out      (acc_z_out),
        .o_gyro_x_out     (gyro_x_out),
        .o_gyro_y_out     (gyro_y_out),
        .o_gyro_z_out     (gyro_z_out),
        .o_gyro_cal_busy  (gyro_busy_out),
        .o_acc_cal_busy   (acc_busy_out),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data)
    );

    // Model state of the block
    t_sample         gyro_ofs [AXES];
    t_sample         acc_ofs [AXES];
    t_sum            gyro_bias_sum [AXES];
    t_sum            acc_bias_sum [2];
    logic [CNT_W-1:0] gyro_step;
    logic [CNT_W-1:0] acc_step;
    logic            gyro_running;
    logic            acc_running;
    logic [DB_W-1:0] z_deadband;

    // Corrected samples still owed by the block, oldest first
    t_result corrected_q [$];

    int   err_count = 0;
    int   items_sent = 0;
    int   calm_mark = 0;
    int   cycle_count = 0;
    bit   idle_en = 1'b1;
    bit   hold_off_req = 1'b0;
    bit   rx_holding = 1'b0;
    t_sample centers [6];

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want)
            report_error($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    function automatic t_sample sat_diff(input t_sample a, input t_sample b);
        int d;
        d = int'(a) - int'(b);
        if (d > 32767) d = 32767;
        if (d < -32768) d = -32768;
        return t_sample'(d);
    endfunction

    // Corrects one sample and advances the calibration state
    function automatic t_result correct_sample(input t_imu_frame f);
        t_result r;
        t_sample raw_a [AXES];
        t_sample raw_g [AXES];
        t_sample a [AXES];
        t_sample g [AXES];
        logic    acc_may_step;
        int      db;
        int      k;
        raw_a[0] = f.acc_x;  raw_a[1] = f.acc_y;  raw_a[2] = f.acc_z;
        raw_g[0] = f.gyro_x; raw_g[1] = f.gyro_y; raw_g[2] = f.gyro_z;
        for (k = 0; k < AXES; k++) begin
            a[k] = sat_diff(raw_a[k], acc_ofs[k]);
            g[k] = sat_diff(raw_g[k], gyro_ofs[k]);
        end
        // gyro Z deadband, edges included
        db = int'(z_deadband);
        if (int'(g[2]) >= -db && int'(g[2]) <= db) g[2] = '0;
        r.acc_x  = a[0]; r.acc_y  = a[1]; r.acc_z  = a[2];
        r.gyro_x = g[0]; r.gyro_y = g[1]; r.gyro_z = g[2];

        if (f.start_gyro) gyro_running = 1'b1;
        if (f.start_acc) acc_running = 1'b1;
        acc_may_step = 1'b1;

        // gyro calibration step; its clear and finish items block the accel step
        if (gyro_running) begin
            if (gyro_step == '0) begin
                for (k = 0; k < AXES; k++) begin
                    gyro_bias_sum[k] = '0;
                    gyro_ofs[k] = '0;
                end
                gyro_step = CNT_W'(1);
                acc_may_step = 1'b0;
            end else begin
                for (k = 0; k < AXES; k++)
                    gyro_bias_sum[k] = gyro_bias_sum[k] + t_sum'(g[k]);
                if (gyro_step == CNT_W'(CAL_SAMPLES)) begin
                    for (k = 0; k < AXES; k++)
                        gyro_ofs[k] = t_sample'(int'(gyro_bias_sum[k]) / CAL_SAMPLES);
                    gyro_step = '0;
                    gyro_running = 1'b0;
                    acc_may_step = 1'b0;
                end else begin
                    gyro_step = gyro_step + CNT_W'(1);
                end
            end
        end

        // accel calibration step; Z offset stays zero to keep gravity
        if (acc_may_step && acc_running) begin
            if (acc_step == '0) begin
                acc_bias_sum[0] = '0;
                acc_bias_sum[1] = '0;
                for (k = 0; k < AXES; k++) acc_ofs[k] = '0;
                acc_step = CNT_W'(1);
            end else begin
                acc_bias_sum[0] = acc_bias_sum[0] + t_sum'(a[0]);
                acc_bias_sum[1] = acc_bias_sum[1] + t_sum'(a[1]);
                if (acc_step == CNT_W'(CAL_SAMPLES)) begin
                    acc_ofs[0] = t_sample'(int'(acc_bias_sum[0]) / CAL_SAMPLES);
                    acc_ofs[1] = t_sample'(int'(acc_bias_sum[1]) / CAL_SAMPLES);
                    acc_ofs[2] = '0;
                    acc_step = '0;
                    acc_running = 1'b0;
                end else begin
                    acc_step = acc_step + CNT_W'(1);
                end
            end
        end

        r.gyro_busy = gyro_running;
        r.acc_busy = acc_running;
        return r;
    endfunction

    function automatic t_imu_frame frm(input int ax, input int ay, input int az,
                                       input int gx, input int gy, input int gz,
                                       input bit sg, input bit sa);
        return {t_sample'(ax), t_sample'(ay), t_sample'(az),
                t_sample'(gx), t_sample'(gy), t_sample'(gz), sg, sa};
    endfunction

    function automatic t_result res(input int ax, input int ay, input int az,
                                    input int gx, input int gy, input int gz,
                                    input bit gb, input bit ab);
        return {t_sample'(ax), t_sample'(ay), t_sample'(az),
                t_sample'(gx), t_sample'(gy), t_sample'(gz), gb, ab};
    endfunction

    function automatic t_sample gen_value(input t_val_mode m, input t_sample ctr);
        int v;
        case (m)
            VAL_NEAR: begin
                v = int'(ctr) + int'($urandom_range(0, 64)) - 32;
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
            end
            VAL_EXTREME: begin
                case ($urandom_range(0, 5))
                    0: v = 32767;
                    1: v = -32768;
                    2: v = -1;
                    3: v = 0;
                    4: v = 1;
                    default: v = int'($urandom_range(0, 65535)) - 32768;
                endcase
            end
            default: v = int'($urandom_range(0, 65535)) - 32768;
        endcase
        return t_sample'(v);
    endfunction

    function automatic t_imu_frame gen_frame(input t_val_mode m, input bit sg, input bit sa);
        t_imu_frame f;
        f.acc_x  = gen_value(m, centers[0]);
        f.acc_y  = gen_value(m, centers[1]);
        f.acc_z  = gen_value(m, centers[2]);
        f.gyro_x = gen_value(m, centers[3]);
        f.gyro_y = gen_value(m, centers[4]);
        f.gyro_z = gen_value(m, centers[5]);
        f.start_gyro = sg;
        f.start_acc = sa;
        return f;
    endfunction

    // Offers one sample transaction; called and returns at a falling edge
    task automatic push_frame(input t_imu_frame f, input bit typed, input t_result given);
        t_result predicted;
        int gap;
        if (items_sent >= calm_mark && calm_mark != 0) idle_en = 1'b0;
        if (idle_en && !hold_off_req && !rx_holding && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_frame <= f;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (in_stall);
        predicted = correct_sample(f);
        corrected_q.push_back(typed ? given : predicted);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Deadband write, only once the block has drained
    task automatic write_deadband(input logic [DB_W-1:0] v);
        in_valid <= 1'b0;
        while (corrected_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ready);
        z_deadband = v;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request
    initial begin : rx_stall_gen
        int n;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                rx_holding = 1'b1;
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                out_stall <= 1'b0;
                rx_holding = 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 7);
                out_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Result check against the oldest pending sample
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (corrected_q.size() == 0) begin
                report_error("result transaction with no sample pending");
            end else begin
                want = corrected_q.pop_front();
                compare_field("acc_x_out", acc_x_out, want.acc_x);
                compare_field("acc_y_out", acc_y_out, want.acc_y);
                compare_field("acc_z_out", acc_z_out, want.acc_z);
                compare_field("gyro_x_out", gyro_x_out, want.gyro_x);
                compare_field("gyro_y_out", gyro_y_out, want.gyro_y);
                compare_field("gyro_z_out", gyro_z_out, want.gyro_z);
                compare_field("gyro_cal_busy", gyro_busy_out, want.gyro_busy);
                compare_field("acc_cal_busy", acc_busy_out, want.acc_busy);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Main sequence
    initial begin : main_seq
        t_dir_row    dir_rows [$];
        t_phase_kind kind;
        t_imu_frame  f;
        int          phase;
        int          n_dir;
        int          i;
        int          len;
        int          r;
        int          drain;
        logic [DB_W-1:0] db;

        // model reset
        for (i = 0; i < AXES; i++) begin
            gyro_ofs[i] = '0;
            acc_ofs[i] = '0;
            gyro_bias_sum[i] = '0;
        end
        acc_bias_sum[0] = '0;
        acc_bias_sum[1] = '0;
        gyro_step = '0;
        acc_step = '0;
        gyro_running = 1'b0;
        acc_running = 1'b0;
        z_deadband = DB_RESET;
        for (i = 0; i < 6; i++) centers[i] = '0;

        // Directed rows: zero offsets and deadband 5 after reset
        dir_rows.push_back({frm(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, res(0, 0, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back({frm(32767, 32767, 32767, 32767, 32767, 32767, 0, 0), 1'b1,
                            res(32767, 32767, 32767, 32767, 32767, 32767, 0, 0)});
        dir_rows.push_back({frm(-32768, -32768, -32768, -32768, -32768, -32768, 0, 0), 1'b1,
                            res(-32768, -32768, -32768, -32768, -32768, -32768, 0, 0)});
        // deadband edges on gyro Z
        dir_rows.push_back({frm(1, -1, 2, -2, 3, 5, 0, 0), 1'b1, res(1, -1, 2, -2, 3, 0, 0, 0)});
        dir_rows.push_back({frm(7, 8, 9, 10, 11, -5, 0, 0), 1'b1, res(7, 8, 9, 10, 11, 0, 0, 0)});
        dir_rows.push_back({frm(0, 0, 0, 0, 0, 6, 0, 0), 1'b1, res(0, 0, 0, 0, 0, 6, 0, 0)});
        dir_rows.push_back({frm(0, 0, 0, 0, 0, -6, 0, 0), 1'b1, res(0, 0, 0, 0, 0, -6, 0, 0)});
        // alternating bit patterns
        dir_rows.push_back({frm(21845, -21846, 21845, -21846, 21845, -21846, 0, 0), 1'b1,
                            res(21845, -21846, 21845, -21846, 21845, -21846, 0, 0)});
        dir_rows.push_back({frm(-21846, 21845, -21846, 21845, -21846, 21845, 0, 0), 1'b1,
                            res(-21846, 21845, -21846, 21845, -21846, 21845, 0, 0)});
        // gyro calibration start: old offsets still apply, busy rises
        dir_rows.push_back({frm(100, 200, 300, 400, 500, 600, 1, 0), 1'b1,
                            res(100, 200, 300, 400, 500, 600, 1, 0)});
        // repeated gyro request while running
        dir_rows.push_back({frm(110, 210, 310, 410, 510, 4, 1, 0), 1'b1,
                            res(110, 210, 310, 410, 510, 0, 1, 0)});
        // accel request joins while gyro is mid-run
        dir_rows.push_back({frm(-100, -200, 16384, 20, 30, 40, 0, 1), 1'b1,
                            res(-100, -200, 16384, 20, 30, 40, 1, 1)});
        // both requests while both are already running
        dir_rows.push_back({frm(32767, -32768, 1, -1, 32767, -32768, 1, 1), 1'b0, t_result'(0)});
        dir_rows.push_back({frm(-32768, 32767, -1, 1, -32768, 32767, 0, 0), 1'b0, t_result'(0)});
        dir_rows.push_back({frm(12345, -12345, 4096, -4096, 255, -255, 0, 0), 1'b0,
                            t_result'(0)});
        dir_rows.push_back({frm(-1, -1, -1, -1, -1, -1, 1, 1), 1'b0, t_result'(0)});
        n_dir = dir_rows.size();

        // hold reset, then release it
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k])
            push_frame(dir_rows[k].frame, dir_rows[k].typed, dir_rows[k].result);

        // Random phases, each under its own deadband setting
        calm_mark = n_dir + RANDOM_ITEMS - CALM_ITEMS;
        phase = 0;
        while (items_sent < n_dir + RANDOM_ITEMS) begin
            case (phase)
                0: db = '0;
                1: db = '1;
                2: db = DB_RESET;
                default: begin
                    case ($urandom_range(0, 3))
                        0: db = '0;
                        1: db = '1;
                        default: db = DB_W'($urandom_range(0, 255));
                    endcase
                end
            endcase
            write_deadband(db);
            idle_en = (items_sent < calm_mark) && ($urandom_range(0, 3) != 0);
            for (i = 0; i < 6; i++) centers[i] = gen_value(VAL_UNIFORM, '0);

            case (phase)
                0: kind = PH_NOISE;
                1: kind = PH_GYRO_CAL;
                2: kind = PH_ACC_CAL;
                3: kind = PH_BOTH_CAL;
                default: kind = t_phase_kind'($urandom_range(0, 3));
            endcase

            // long receiver hold-off while the sender keeps offering
            if (phase == 1) begin
                idle_en = (items_sent < calm_mark);
                hold_off_req = 1'b1;
            end

            if (kind == PH_NOISE) begin
                len = (phase == 0) ? 260 : $urandom_range(40, 120);
                for (i = 0; i < len; i++) begin
                    r = $urandom_range(0, 9);
                    f = gen_frame(r < 6 ? VAL_UNIFORM : (r < 8 ? VAL_EXTREME : VAL_NEAR),
                                  $urandom_range(0, 99) == 0, $urandom_range(0, 99) == 0);
                    push_frame(f, 1'b0, t_result'(0));
                end
            end else begin
                // well-formed calibration run around a random bias
                f = gen_frame(VAL_NEAR, kind != PH_ACC_CAL, kind != PH_GYRO_CAL);
                push_frame(f, 1'b0, t_result'(0));
                for (i = 0; i < CAL_SAMPLES + 2; i++) begin
                    r = $urandom_range(0, 19);
                    f = gen_frame(r < 18 ? VAL_NEAR : VAL_UNIFORM,
                                  (kind != PH_ACC_CAL) && (r == 19),
                                  (kind != PH_GYRO_CAL) && (r == 19));
                    push_frame(f, 1'b0, t_result'(0));
                end
                // extremes against the fresh offsets drive the subtract into saturation
                for (i = 0; i < 20; i++) begin
                    f = gen_frame(VAL_EXTREME, 1'b0, 1'b0);
                    push_frame(f, 1'b0, t_result'(0));
                end
            end
            phase++;
        end
        in_valid <= 1'b0;

        // drain, then a short quiet tail
        drain = 0;
        while (corrected_q.size() != 0 && drain < DRAIN_LIMIT) begin
            @(negedge i_clk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (corrected_q.size() != 0)
            report_error($sformatf("%0d samples never produced a result",
                                   corrected_q.size()));

        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
